// File: hdl/rbs_pkg.sv
// ---------------------------------------------------------------------------
// rbs_pkg - shared types and helpers for the ray/box slab intersect core
// Fixed-point widths, pipeline depths and saturation helpers.
// ---------------------------------------------------------------------------
package rbs_pkg;

   localparam int CW        = 32;               // coordinate width
   localparam int FRAC      = 16;               // fraction bits
   localparam int MAG_W     = CW + 1;           // |box - origin|
   localparam int DIV_W     = MAG_W + FRAC;     // dividend / quotient width
   localparam int PROD_W    = 2 * CW;           // |t| * |dir|
   localparam int LANE_LAT  = DIV_W + 2;        // prep + divider + order
   localparam int TOTAL_LAT = LANE_LAT + 3;     // + merge + multiply + add
   localparam int REQ_W     = 12 * CW;
   localparam int REQ_TDATA_W = ((REQ_W + 7) / 8) * 8;
   localparam int RSP_W     = 1 + 8 * CW;
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic [CW-1:0]        umag_type;
   typedef logic [DIV_W-1:0]     quot_type;
   typedef logic [PROD_W-1:0]    prod_type;

   typedef struct packed {
      logic      hit;
      coord_type t_entry;
      coord_type t_exit;
      coord_type entry_x;
      coord_type entry_y;
      coord_type entry_z;
      coord_type exit_x;
      coord_type exit_y;
      coord_type exit_z;
   } rsp_type;

   function automatic umag_type mag_of(input coord_type x);
      umag_type r;
      r = x[CW-1] ? umag_type'(-x) : umag_type'(x);
      return r;
   endfunction

   // clamp unsigned quotient to the signed range, then apply sign
   function automatic coord_type sat_quot(input quot_type q, input logic neg);
      quot_type cap;
      quot_type qs;
      quot_type r;
      cap = quot_type'({1'b0, {(CW-1){1'b1}}}) + quot_type'(neg);
      qs  = (q > cap) ? cap : q;
      r   = neg ? (~qs + quot_type'(1)) : qs;
      return coord_type'(r[CW-1:0]);
   endfunction

   // o +/- (p >> FRAC), saturated
   function automatic coord_type sat_point(input coord_type o, input logic neg,
                                           input prod_type p);
      logic signed [PROD_W+1:0] ow;
      logic signed [PROD_W+1:0] mw;
      logic signed [PROD_W+1:0] s;
      logic signed [PROD_W+1:0] smax;
      logic signed [PROD_W+1:0] smin;
      ow   = {{(PROD_W+2-CW){o[CW-1]}}, o};
      mw   = {2'b00, p >> FRAC};
      s    = neg ? (ow - mw) : (ow + mw);
      smax = {{(PROD_W+3-CW){1'b0}}, {(CW-1){1'b1}}};
      smin = ~smax;
      if (s > smax)      return coord_type'(smax[CW-1:0]);
      else if (s < smin) return coord_type'(smin[CW-1:0]);
      else               return coord_type'(s[CW-1:0]);
   endfunction

endpackage

// File: hdl/rbs_div.sv
// ---------------------------------------------------------------------------
// rbs_div - pipelined restoring divider
// One quotient bit per stage, one new division accepted per enabled cycle.
// ---------------------------------------------------------------------------
module rbs_div (
   input  logic                clock,
   input  logic                en,
   input  rbs_pkg::quot_type   num,
   input  rbs_pkg::umag_type   den,
   input  logic                neg,
   output rbs_pkg::quot_type   quot,
   output logic                quot_neg
);

   rbs_pkg::umag_type rem_ff [1:rbs_pkg::DIV_W];
   rbs_pkg::quot_type num_ff [1:rbs_pkg::DIV_W];
   rbs_pkg::quot_type q_ff   [1:rbs_pkg::DIV_W];
   rbs_pkg::umag_type den_ff [1:rbs_pkg::DIV_W];
   logic              neg_ff [1:rbs_pkg::DIV_W];

   for (genvar s = 0; s < rbs_pkg::DIV_W; s++) begin : g_stage
      rbs_pkg::umag_type    rem_cur;
      rbs_pkg::quot_type    num_cur;
      rbs_pkg::quot_type    q_cur;
      rbs_pkg::umag_type    den_cur;
      logic                 neg_cur;
      logic [rbs_pkg::CW:0] rem_sh;
      logic [rbs_pkg::CW:0] rem_sub;
      logic                 ge;
      rbs_pkg::umag_type    rem_in;

      if (s == 0) begin : g_first
         assign rem_cur = '0;
         assign num_cur = num;
         assign q_cur   = '0;
         assign den_cur = den;
         assign neg_cur = neg;
      end else begin : g_next
         assign rem_cur = rem_ff[s];
         assign num_cur = num_ff[s];
         assign q_cur   = q_ff[s];
         assign den_cur = den_ff[s];
         assign neg_cur = neg_ff[s];
      end

      always_comb begin
         rem_sh  = {rem_cur, num_cur[rbs_pkg::DIV_W-1]};
         ge      = rem_sh >= {1'b0, den_cur};
         rem_sub = rem_sh - {1'b0, den_cur};
         rem_in  = ge ? rem_sub[rbs_pkg::CW-1:0] : rem_sh[rbs_pkg::CW-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= rem_in;
            num_ff[s+1] <= {num_cur[rbs_pkg::DIV_W-2:0], 1'b0};
            q_ff[s+1]   <= {q_cur[rbs_pkg::DIV_W-2:0], ge};
            den_ff[s+1] <= den_cur;
            neg_ff[s+1] <= neg_cur;
         end
      end
   end

   assign quot     = q_ff[rbs_pkg::DIV_W];
   assign quot_neg = neg_ff[rbs_pkg::DIV_W];

endmodule

// File: hdl/rbs_lane.sv
// ---------------------------------------------------------------------------
// rbs_lane - one axis of the slab test
// Slab differences, two dividers, zero-direction handling and ordering.
// ---------------------------------------------------------------------------
module rbs_lane (
   input  logic               clock,
   input  logic               en,
   input  rbs_pkg::coord_type origin,
   input  rbs_pkg::coord_type dir,
   input  rbs_pkg::coord_type bmin,
   input  rbs_pkg::coord_type bmax,
   output rbs_pkg::coord_type t_near,
   output rbs_pkg::coord_type t_far
);

   logic signed [rbs_pkg::MAG_W-1:0] dlo, dhi;
   logic [rbs_pkg::MAG_W-1:0]        mlo, mhi;

   rbs_pkg::quot_type num_lo_ff, num_hi_ff;
   rbs_pkg::umag_type den_ff;
   logic              neg_lo_ff, neg_hi_ff;
   logic              zero_ff  [0:rbs_pkg::DIV_W];
   logic              inslab_ff[0:rbs_pkg::DIV_W];

   rbs_pkg::quot_type q_lo, q_hi;
   logic              qn_lo, qn_hi;
   rbs_pkg::coord_type p_val, q_val, a_in, b_in;
   rbs_pkg::coord_type t_near_ff, t_far_ff;

   always_comb begin
      dlo = {bmin[rbs_pkg::CW-1], bmin} - {origin[rbs_pkg::CW-1], origin};
      dhi = {bmax[rbs_pkg::CW-1], bmax} - {origin[rbs_pkg::CW-1], origin};
      mlo = dlo[rbs_pkg::MAG_W-1] ? -dlo : dlo;
      mhi = dhi[rbs_pkg::MAG_W-1] ? -dhi : dhi;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_lo_ff    <= {mlo, {rbs_pkg::FRAC{1'b0}}};
         num_hi_ff    <= {mhi, {rbs_pkg::FRAC{1'b0}}};
         den_ff       <= rbs_pkg::mag_of(dir);
         neg_lo_ff    <= dlo[rbs_pkg::MAG_W-1] ^ dir[rbs_pkg::CW-1];
         neg_hi_ff    <= dhi[rbs_pkg::MAG_W-1] ^ dir[rbs_pkg::CW-1];
         zero_ff[0]   <= (dir == '0);
         inslab_ff[0] <= (bmin <= origin) && (origin <= bmax);
      end
   end

   for (genvar s = 0; s < rbs_pkg::DIV_W; s++) begin : g_flag
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[s+1]   <= zero_ff[s];
            inslab_ff[s+1] <= inslab_ff[s];
         end
      end
   end

   rbs_div u_div_lo (
      .clock(clock), .en(en), .num(num_lo_ff), .den(den_ff), .neg(neg_lo_ff),
      .quot(q_lo), .quot_neg(qn_lo)
   );

   rbs_div u_div_hi (
      .clock(clock), .en(en), .num(num_hi_ff), .den(den_ff), .neg(neg_hi_ff),
      .quot(q_hi), .quot_neg(qn_hi)
   );

   always_comb begin
      p_val = rbs_pkg::sat_quot(q_lo, qn_lo);
      q_val = rbs_pkg::sat_quot(q_hi, qn_hi);
      if (zero_ff[rbs_pkg::DIV_W]) begin
         // parallel to the slab: whole line inside, or none of it
         if (inslab_ff[rbs_pkg::DIV_W]) begin
            a_in = {1'b1, {(rbs_pkg::CW-1){1'b0}}};
            b_in = {1'b0, {(rbs_pkg::CW-1){1'b1}}};
         end else begin
            a_in = {1'b0, {(rbs_pkg::CW-1){1'b1}}};
            b_in = {1'b1, {(rbs_pkg::CW-1){1'b0}}};
         end
      end else if (p_val < q_val) begin
         a_in = p_val;
         b_in = q_val;
      end else begin
         a_in = q_val;
         b_in = p_val;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_near_ff <= a_in;
         t_far_ff  <= b_in;
      end
   end

   assign t_near = t_near_ff;
   assign t_far  = t_far_ff;

endmodule

// File: hdl/rbs_merge.sv
// ---------------------------------------------------------------------------
// rbs_merge - combine lane results and form entry/exit points
// Max/min over the three axes, then t*dir products and saturated adds.
// ---------------------------------------------------------------------------
module rbs_merge (
   input  logic               clock,
   input  logic               en,
   input  rbs_pkg::coord_type t_near [3],
   input  rbs_pkg::coord_type t_far  [3],
   input  rbs_pkg::coord_type origin [3],
   input  rbs_pkg::coord_type dir    [3],
   output rbs_pkg::rsp_type   result
);

   rbs_pkg::coord_type te_in, tx_in;

   rbs_pkg::coord_type te_ff, tx_ff;
   logic               hit_ff;
   rbs_pkg::coord_type o1_ff [3];
   rbs_pkg::coord_type d1_ff [3];

   rbs_pkg::coord_type te2_ff, tx2_ff;
   logic               hit2_ff;
   rbs_pkg::coord_type o2_ff  [3];
   rbs_pkg::prod_type  pe_ff  [3];
   rbs_pkg::prod_type  px_ff  [3];
   logic               ne_ff  [3];
   logic               nx_ff  [3];

   rbs_pkg::rsp_type   result_ff;

   always_comb begin
      te_in = t_near[0];
      tx_in = t_far[0];
      for (int k = 1; k < 3; k++) begin
         if (t_near[k] > te_in) te_in = t_near[k];
         if (t_far[k]  < tx_in) tx_in = t_far[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         te_ff  <= te_in;
         tx_ff  <= tx_in;
         hit_ff <= (te_in <= tx_in);
         o1_ff  <= origin;
         d1_ff  <= dir;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         te2_ff  <= te_ff;
         tx2_ff  <= tx_ff;
         hit2_ff <= hit_ff;
         o2_ff   <= o1_ff;
         for (int k = 0; k < 3; k++) begin
            pe_ff[k] <= rbs_pkg::PROD_W'(rbs_pkg::mag_of(te_ff))
                        * rbs_pkg::PROD_W'(rbs_pkg::mag_of(d1_ff[k]));
            px_ff[k] <= rbs_pkg::PROD_W'(rbs_pkg::mag_of(tx_ff))
                        * rbs_pkg::PROD_W'(rbs_pkg::mag_of(d1_ff[k]));
            ne_ff[k] <= te_ff[rbs_pkg::CW-1] ^ d1_ff[k][rbs_pkg::CW-1];
            nx_ff[k] <= tx_ff[rbs_pkg::CW-1] ^ d1_ff[k][rbs_pkg::CW-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff.hit     <= hit2_ff;
         result_ff.t_entry <= te2_ff;
         result_ff.t_exit  <= tx2_ff;
         result_ff.entry_x <= rbs_pkg::sat_point(o2_ff[0], ne_ff[0], pe_ff[0]);
         result_ff.entry_y <= rbs_pkg::sat_point(o2_ff[1], ne_ff[1], pe_ff[1]);
         result_ff.entry_z <= rbs_pkg::sat_point(o2_ff[2], ne_ff[2], pe_ff[2]);
         result_ff.exit_x  <= rbs_pkg::sat_point(o2_ff[0], nx_ff[0], px_ff[0]);
         result_ff.exit_y  <= rbs_pkg::sat_point(o2_ff[1], nx_ff[1], px_ff[1]);
         result_ff.exit_z  <= rbs_pkg::sat_point(o2_ff[2], nx_ff[2], px_ff[2]);
      end
   end

   assign result = result_ff;

endmodule

// File: hdl/ray_box_slab_intersect_core.sv
// ---------------------------------------------------------------------------
// ray_box_slab_intersect_core - streaming ray / axis-aligned box test
// Three axis lanes, a merge stage and point evaluation, fully pipelined.
// ---------------------------------------------------------------------------
// One ray/box test enters per cycle while the pipe advances, and results leave
// in the order the tests entered. The depth is set by the restoring
// dividers in each axis lane, which resolve one quotient bit per stage;
// the remaining stages are slab preparation, ordering, the axis merge, the
// t*dir multiply and the saturating add. The whole pipe advances whenever
// the output register is empty or being drained, so a stalled result
// stops the pipe and nothing is lost.
module ray_box_slab_intersect_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // origin_x/y/z, dir_x/y/z, box_min_x/y/z, box_max_x/y/z (lowest first)
   input  logic [rbs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // hit, t_entry, t_exit, entry_x/y/z, exit_x/y/z, zero pad (lowest first)
   output logic [rbs_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int CW = rbs_pkg::CW;

   logic en;
   logic vld_ff [0:rbs_pkg::TOTAL_LAT-1];

   rbs_pkg::coord_type f [12];
   rbs_pkg::coord_type o_ff [0:rbs_pkg::LANE_LAT-1][3];
   rbs_pkg::coord_type d_ff [0:rbs_pkg::LANE_LAT-1][3];
   rbs_pkg::coord_type t_near [3];
   rbs_pkg::coord_type t_far  [3];
   rbs_pkg::rsp_type   result;

   assign en         = !vld_ff[rbs_pkg::TOTAL_LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[rbs_pkg::TOTAL_LAT-1];

   always_comb begin
      for (int i = 0; i < 12; i++) f[i] = req_tdata[i*CW +: CW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < rbs_pkg::TOTAL_LAT; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int s = 1; s < rbs_pkg::TOTAL_LAT; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   // origin and direction ride alongside the lanes to the merge
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            o_ff[0][k] <= f[k];
            d_ff[0][k] <= f[3+k];
         end
         for (int s = 1; s < rbs_pkg::LANE_LAT; s++) begin
            o_ff[s] <= o_ff[s-1];
            d_ff[s] <= d_ff[s-1];
         end
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_lane
      rbs_lane u_lane (
         .clock(clock), .en(en),
         .origin(f[k]), .dir(f[3+k]), .bmin(f[6+k]), .bmax(f[9+k]),
         .t_near(t_near[k]), .t_far(t_far[k])
      );
   end

   rbs_merge u_merge (
      .clock(clock), .en(en),
      .t_near(t_near), .t_far(t_far),
      .origin(o_ff[rbs_pkg::LANE_LAT-1]), .dir(d_ff[rbs_pkg::LANE_LAT-1]),
      .result(result)
   );

   assign rsp_tdata = {{(rbs_pkg::RSP_TDATA_W-rbs_pkg::RSP_W){1'b0}},
                       result.exit_z, result.exit_y, result.exit_x,
                       result.entry_z, result.entry_y, result.entry_x,
                       result.t_exit, result.t_entry, result.hit};

endmodule

// File: hdl/rbs_checker.sv
// ---------------------------------------------------------------------------
// rbs_checker - port-level checks for the slab intersect core
// Flow control, reset behaviour and result consistency.
// ---------------------------------------------------------------------------
module rbs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [rbs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rbs_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int CW = rbs_pkg::CW;

   // input side takes a transfer whenever the output can move
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not follow output flow");

   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] ==
         ($signed(rsp_tdata[CW:1]) <= $signed(rsp_tdata[2*CW:CW+1]))))
      else $error("hit flag disagrees with t_entry/t_exit");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[rbs_pkg::RSP_TDATA_W-1:rbs_pkg::RSP_W] == '0))
      else $error("tdata padding not zero");

endmodule

bind ray_box_slab_intersect_core rbs_checker u_rbs_checker (.*);

// File: dv/tb_ray_box_slab_intersect_core.sv
// ---------------------------------------------------------------------------
// tb_ray_box_slab_intersect_core - stream test of the ray/box slab core
// Drives random and corner-case ray/box items with random gaps on both
// sides, predicts each result in Q16.16 and compares it field by field.
// ---------------------------------------------------------------------------
module tb_ray_box_slab_intersect_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     CW          = rbs_pkg::CW;
   localparam int     FRAC        = rbs_pkg::FRAC;
   localparam int     REQ_TDATA_W = rbs_pkg::REQ_TDATA_W;
   localparam int     RSP_TDATA_W = rbs_pkg::RSP_TDATA_W;
   localparam int     TOTAL_LAT   = rbs_pkg::TOTAL_LAT;
   localparam longint SMAX = 64'sd2147483647;
   localparam longint SMIN = -64'sd2147483648;
   localparam int     CYCLE_LIMIT = 600000;

   typedef struct {
      longint org[3];
      longint dir[3];
      longint bmin[3];
      longint bmax[3];
   } ray_box_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   ray_box_slab_intersect_core u_top (.*);

   logic [REQ_TDATA_W-1:0] pending_rays[$];
   rbs_pkg::rsp_type       expected_hits[$];
   int                     errors = 0;
   int                     cycles = 0;
   bit                     stim_done = 0;
   int                     send_gap = 0;
   int                     recv_gap = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
   endfunction

   // (num - org) / d in Q16.16, truncated toward zero, saturated
   function automatic longint slab_param(input longint num, input longint org,
                                         input longint d);
      logic [127:0] n, dv, q;
      longint       diff;
      bit           neg;
      diff = num - org;
      neg  = (diff < 0) != (d < 0);
      n    = 128'(diff < 0 ? -diff : diff) << FRAC;
      dv   = 128'(d < 0 ? -d : d);
      q    = n / dv;
      if (neg) begin
         if (q > 128'd2147483648) q = 128'd2147483648;
         return -longint'(q);
      end
      if (q > 128'd2147483647) q = 128'd2147483647;
      return longint'(q);
   endfunction

   // org + t*d with the product magnitude truncated, sum saturated
   function automatic longint ray_point(input longint org, input longint t,
                                        input longint d);
      logic [127:0] p;
      longint       m;
      p = 128'(t < 0 ? -t : t) * 128'(d < 0 ? -d : d);
      p = p >> FRAC;
      m = longint'(p[62:0]);   // at most 2^46, no overflow
      return clamp32(((t < 0) != (d < 0)) ? org - m : org + m);
   endfunction

   function automatic rbs_pkg::rsp_type predict_hit(input ray_box_type rb);
      rbs_pkg::rsp_type r;
      longint           te, tx, a, b, p, q;
      te = SMIN;
      tx = SMAX;
      for (int k = 0; k < 3; k++) begin
         if (rb.dir[k] == 0) begin
            if (rb.bmin[k] <= rb.org[k] && rb.org[k] <= rb.bmax[k]) begin
               a = SMIN; b = SMAX;
            end else begin
               a = SMAX; b = SMIN;
            end
         end else begin
            p = slab_param(rb.bmin[k], rb.org[k], rb.dir[k]);
            q = slab_param(rb.bmax[k], rb.org[k], rb.dir[k]);
            a = p < q ? p : q;
            b = p < q ? q : p;
         end
         if (a > te) te = a;
         if (b < tx) tx = b;
      end
      r.hit     = te <= tx;
      r.t_entry = rbs_pkg::coord_type'(te);
      r.t_exit  = rbs_pkg::coord_type'(tx);
      r.entry_x = rbs_pkg::coord_type'(ray_point(rb.org[0], te, rb.dir[0]));
      r.entry_y = rbs_pkg::coord_type'(ray_point(rb.org[1], te, rb.dir[1]));
      r.entry_z = rbs_pkg::coord_type'(ray_point(rb.org[2], te, rb.dir[2]));
      r.exit_x  = rbs_pkg::coord_type'(ray_point(rb.org[0], tx, rb.dir[0]));
      r.exit_y  = rbs_pkg::coord_type'(ray_point(rb.org[1], tx, rb.dir[1]));
      r.exit_z  = rbs_pkg::coord_type'(ray_point(rb.org[2], tx, rb.dir[2]));
      return r;
   endfunction

   function automatic logic [REQ_TDATA_W-1:0] pack_ray(input ray_box_type rb);
      logic [REQ_TDATA_W-1:0] v;
      v = '0;
      for (int k = 0; k < 3; k++) begin
         v[k*CW +: CW]     = rb.org[k][CW-1:0];
         v[(3+k)*CW +: CW] = rb.dir[k][CW-1:0];
         v[(6+k)*CW +: CW] = rb.bmin[k][CW-1:0];
         v[(9+k)*CW +: CW] = rb.bmax[k][CW-1:0];
      end
      return v;
   endfunction

   function automatic ray_box_type unpack_ray(input logic [REQ_TDATA_W-1:0] v);
      ray_box_type rb;
      for (int k = 0; k < 3; k++) begin
         rb.org[k]  = longint'(rbs_pkg::coord_type'(v[k*CW +: CW]));
         rb.dir[k]  = longint'(rbs_pkg::coord_type'(v[(3+k)*CW +: CW]));
         rb.bmin[k] = longint'(rbs_pkg::coord_type'(v[(6+k)*CW +: CW]));
         rb.bmax[k] = longint'(rbs_pkg::coord_type'(v[(9+k)*CW +: CW]));
      end
      return rb;
   endfunction

   function automatic longint rand_coord(input int mode);
      case (mode)
         0:       return longint'(rbs_pkg::coord_type'($urandom()));
         1:       return longint'($urandom_range(0, 40 << 16)) - (20 << 16);
         2:       return longint'($urandom_range(0, 1024)) - 512;
         default: return ($urandom_range(0, 1)) ? SMAX - $urandom_range(0, 3)
                                                : SMIN + $urandom_range(0, 3);
      endcase
   endfunction

   task automatic queue_ray(input ray_box_type rb);
      pending_rays.push_back(pack_ray(rb));
   endtask

   task automatic fill_all(output ray_box_type rb, input longint o, input longint d,
                           input longint lo, input longint hi);
      for (int k = 0; k < 3; k++) begin
         rb.org[k] = o; rb.dir[k] = d; rb.bmin[k] = lo; rb.bmax[k] = hi;
      end
   endtask

   initial begin
      ray_box_type rb;
      longint      t0, t1;
      int          mode;
      // directed: unit box, ray through it
      fill_all(rb, -(5 << 16), 1 << 16, -(1 << 16), 1 << 16);
      queue_ray(rb);
      // box behind the ray, then negative direction toward the box
      fill_all(rb, 5 << 16, 1 << 16, -(1 << 16), 1 << 16);
      queue_ray(rb);
      fill_all(rb, 5 << 16, -(1 << 16), -(1 << 16), 1 << 16);
      queue_ray(rb);
      // zero direction: inside, on a face, outside
      fill_all(rb, 0, 0, -(1 << 16), 1 << 16);
      queue_ray(rb);
      fill_all(rb, 1 << 16, 0, -(1 << 16), 1 << 16);
      queue_ray(rb);
      fill_all(rb, -(1 << 16), 0, -(1 << 16), 1 << 16);
      queue_ray(rb);
      fill_all(rb, 2 << 16, 0, -(1 << 16), 1 << 16);
      queue_ray(rb);
      rb.dir[0] = 1 << 16;
      queue_ray(rb);
      // extremes and division saturation
      fill_all(rb, SMIN, 1, SMAX, SMAX);
      queue_ray(rb);
      fill_all(rb, SMAX, 1, SMIN, SMIN);
      queue_ray(rb);
      fill_all(rb, SMIN, SMIN, SMIN, SMAX);
      queue_ray(rb);
      fill_all(rb, SMAX, SMAX, SMIN, SMAX);
      queue_ray(rb);
      fill_all(rb, SMAX, -1, SMIN, SMAX);
      queue_ray(rb);
      fill_all(rb, -1, -1, -1, -1);
      queue_ray(rb);
      // swapped corners
      fill_all(rb, 0, 1 << 16, 3 << 16, -(3 << 16));
      queue_ray(rb);
      // separated per-axis intervals: miss with finite parameters
      fill_all(rb, 0, 1 << 16, 1 << 16, 2 << 16);
      rb.bmin[1] = 3 << 16; rb.bmax[1] = 4 << 16;
      queue_ray(rb);
      // mixed zero / nonzero axes with large points
      rb.org = '{SMAX, 0, SMIN}; rb.dir = '{SMIN, 0, SMAX};
      rb.bmin = '{SMIN, SMIN, SMIN}; rb.bmax = '{SMAX, SMAX, SMAX};
      queue_ray(rb);

      // random: mostly bounded boxes and nearby rays, some noise
      for (int i = 0; i < 1650; i++) begin
         mode = $urandom_range(0, 9);
         for (int k = 0; k < 3; k++) begin
            if (mode < 2) begin
               rb.org[k]  = rand_coord($urandom_range(0, 3));
               rb.dir[k]  = rand_coord($urandom_range(0, 3));
               rb.bmin[k] = rand_coord($urandom_range(0, 3));
               rb.bmax[k] = rand_coord($urandom_range(0, 3));
            end else begin
               t0 = rand_coord(mode == 9 ? 0 : 1);
               t1 = t0 + $urandom_range(0, 8 << 16);
               rb.bmin[k] = clamp32(t0);
               rb.bmax[k] = clamp32(t1);
               rb.org[k]  = rand_coord(1) * ($urandom_range(0, 1) ? 1 : 4);
               rb.org[k]  = clamp32(rb.org[k]);
               rb.dir[k]  = ($urandom_range(0, 15) == 0) ? 0 : rand_coord(1);
               if ($urandom_range(0, 7) == 0) rb.dir[k] = rand_coord(2);
            end
         end
         queue_ray(rb);
      end
      stim_done = 1;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) send_gap = pick_gap();
         if (send_gap > 0) begin
            send_gap   = send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_rays.size() > 0) begin
            req_tdata  <= pending_rays[0];
            expected_hits.push_back(predict_hit(unpack_ray(pending_rays[0])));
            void'(pending_rays.pop_front());
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      rbs_pkg::rsp_type got;
      rbs_pkg::rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            // tdata carries hit in bit 0, then the 32-bit fields upwards
            got.hit     = rsp_tdata[0];
            got.t_entry = rsp_tdata[1 +: CW];
            got.t_exit  = rsp_tdata[1 + CW +: CW];
            got.entry_x = rsp_tdata[1 + 2*CW +: CW];
            got.entry_y = rsp_tdata[1 + 3*CW +: CW];
            got.entry_z = rsp_tdata[1 + 4*CW +: CW];
            got.exit_x  = rsp_tdata[1 + 5*CW +: CW];
            got.exit_y  = rsp_tdata[1 + 6*CW +: CW];
            got.exit_z  = rsp_tdata[1 + 7*CW +: CW];
            if (expected_hits.size() == 0) begin
               $error("result transfer with nothing expected");
               errors++;
            end else begin
               want = expected_hits.pop_front();
               if (got.hit !== want.hit) begin
                  $error("hit: expected %0d got %0d", want.hit, got.hit); errors++; end
               if (got.t_entry !== want.t_entry) begin
                  $error("t_entry: expected %0d got %0d", want.t_entry, got.t_entry);
                  errors++; end
               if (got.t_exit !== want.t_exit) begin
                  $error("t_exit: expected %0d got %0d", want.t_exit, got.t_exit);
                  errors++; end
               if (got.entry_x !== want.entry_x) begin
                  $error("entry_x: expected %0d got %0d", want.entry_x, got.entry_x);
                  errors++; end
               if (got.entry_y !== want.entry_y) begin
                  $error("entry_y: expected %0d got %0d", want.entry_y, got.entry_y);
                  errors++; end
               if (got.entry_z !== want.entry_z) begin
                  $error("entry_z: expected %0d got %0d", want.entry_z, got.entry_z);
                  errors++; end
               if (got.exit_x !== want.exit_x) begin
                  $error("exit_x: expected %0d got %0d", want.exit_x, got.exit_x);
                  errors++; end
               if (got.exit_y !== want.exit_y) begin
                  $error("exit_y: expected %0d got %0d", want.exit_y, got.exit_y);
                  errors++; end
               if (got.exit_z !== want.exit_z) begin
                  $error("exit_z: expected %0d got %0d", want.exit_z, got.exit_z);
                  errors++; end
            end
         end
         if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            recv_gap = pick_gap();
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (!(stim_done && pending_rays.size() == 0 && !req_tvalid
               && expected_hits.size() == 0) && cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
      end else begin
         repeat (TOTAL_LAT + 10) @(posedge clock);
         if (errors == 0) $display("CHECK OK");
         else $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

// File: sim.f
hdl/rbs_pkg.sv
hdl/rbs_div.sv
hdl/rbs_lane.sv
hdl/rbs_merge.sv
hdl/ray_box_slab_intersect_core.sv
hdl/rbs_checker.sv
dv/tb_ray_box_slab_intersect_core.sv
